FILE: rtl/mtb_pkg.sv
// ----------------------------------------------------------------------------
// mtb_pkg: shared definitions for the Morse text beacon
// Types, register indexes, the character code table and code length decode.
// ----------------------------------------------------------------------------
`default_nettype none

package mtb_pkg;

    localparam int TEXT_DEPTH = 32;
    localparam int TEXT_AW    = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

    typedef logic [TEXT_AW-1:0] t_text_addr;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_WRITE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        REG_TEXT_LENGTH  = 2'd0,
        REG_DIT_TICKS    = 2'd1,
        REG_WORD_PAUSE   = 2'd2,
        REG_REPEAT_PAUSE = 2'd3
    } t_reg_index;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_SCAN,
        S_DONE
    } t_state;

    // Write port of the text store
    typedef struct packed {
        logic       en;
        t_text_addr addr;
        logic [7:0] data;
    } t_store_wr;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_QUERY   = 8'h3F;
    localparam logic [7:0] CHAR_HYPHEN  = 8'h2D;
    localparam logic [7:0] CHAR_LPAREN  = 8'h28;
    localparam logic [7:0] CHAR_RPAREN  = 8'h29;

    localparam logic [7:0] LETTER_CODES [26] = '{
        8'h60, 8'h88, 8'hA8, 8'h90, 8'h40, 8'h28, 8'hD0, 8'h08, 8'h20, 8'h78,
        8'hB0, 8'h48, 8'hE0, 8'hA0, 8'hF0, 8'h68, 8'hD8, 8'h50, 8'h10, 8'hC0,
        8'h30, 8'h18, 8'h70, 8'h98, 8'hB8, 8'hC8
    };

    localparam logic [7:0] DIGIT_CODES [10] = '{
        8'hFC, 8'h7C, 8'h3C, 8'h1C, 8'h0C, 8'h04, 8'h84, 8'hC4, 8'hE4, 8'hF4
    };

    // Packed code of a character; zero for characters without a code
    function automatic logic [7:0] code_of(input logic [7:0] ch);
        logic [7:0] off;
        logic [7:0] code;
        off  = 8'h00;
        code = 8'h00;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            off  = ch - CHAR_LOWER_A;
            code = LETTER_CODES[off[4:0]];
        end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
            off  = ch - CHAR_DIGIT_0;
            code = DIGIT_CODES[off[3:0]];
        end else begin
            case (ch)
                CHAR_PERIOD: code = 8'h56;
                CHAR_COMMA:  code = 8'hCE;
                CHAR_QUERY:  code = 8'h32;
                CHAR_HYPHEN: code = 8'h86;
                CHAR_LPAREN: code = 8'hB4;
                CHAR_RPAREN: code = 8'hB6;
                default:     code = 8'h00;
            endcase
        end
        return code;
    endfunction

    // Symbol count: seven minus the position of the lowest set bit
    function automatic logic [2:0] length_of(input logic [7:0] code);
        logic [2:0] len;
        len = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (code[b]) begin
                len = 3'(7 - b);
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mtb_text_store.sv
// ----------------------------------------------------------------------------
// mtb_text_store: text character memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mtb_text_store (
    input  wire                       i_clk,
    input  wire mtb_pkg::t_store_wr   i_wr,
    input  wire mtb_pkg::t_text_addr  i_rd_addr,
    output logic [7:0]                o_rd_data
);

    logic [7:0] r_mem [mtb_pkg::TEXT_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/morse_text_beacon.sv
// ----------------------------------------------------------------------------
// morse_text_beacon: repeating Morse code beacon
// Keys a stored text as dits and dahs, one keyer step per tick transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): each transaction is either a
//   text write (i_action = write, i_text_index, i_text_char) or a timer tick
//   (i_action = tick). Every transaction yields exactly one result on the
//   output channel (o_out_valid / i_out_stall) carrying o_light_on.
//   Configuration goes through the APB-style port: text_length at 0x0,
//   dit_ticks at 0x4, word_pause_ticks at 0x8, repeat_pause_ticks at 0xC.
//   A write result passes from the done state into the output register. A
//   tick result passes through the tick state, then the scan state for each
//   character read when the keyer scans text (up to text_length characters,
//   skipping unknown characters in the same tick; a space loads the word
//   pause and ends the scan unless the code register is zero), then done.
//   One transaction is in flight at a time; the input is stalled until its
//   result is loaded into the output register.
//   A new transaction is taken while a finished result waits to be taken.
//   Receiver stall: the result holds in the output register; a following
//   transaction completes its work and then waits for the register to free.
//   Reset: keyer counters clear, light state off, registers return to 0, 1, 5, 40.
//   Text store contents are not cleared; read only entries already written.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_text_beacon (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // input channel
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  wire          i_action,
    input  wire  [4:0]   i_text_index,
    input  wire  [7:0]   i_text_char,
    // output channel
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output logic         o_light_on,
    // configuration port
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [3:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [5:0] r_text_length;
    logic [7:0] r_dit_ticks;
    logic [9:0] r_word_pause;
    logic [9:0] r_repeat_pause;

    logic                w_cfg_wr;
    mtb_pkg::t_reg_index w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = mtb_pkg::t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_length  <= 6'd0;
            r_dit_ticks    <= 8'd1;
            r_word_pause   <= 10'd5;
            r_repeat_pause <= 10'd40;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                mtb_pkg::REG_TEXT_LENGTH:  r_text_length  <= pwdata[5:0];
                mtb_pkg::REG_DIT_TICKS:    r_dit_ticks    <= pwdata[7:0];
                mtb_pkg::REG_WORD_PAUSE:   r_word_pause   <= pwdata[9:0];
                mtb_pkg::REG_REPEAT_PAUSE: r_repeat_pause <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            mtb_pkg::REG_TEXT_LENGTH:  prdata = {26'd0, r_text_length};
            mtb_pkg::REG_DIT_TICKS:    prdata = {24'd0, r_dit_ticks};
            mtb_pkg::REG_WORD_PAUSE:   prdata = {22'd0, r_word_pause};
            mtb_pkg::REG_REPEAT_PAUSE: prdata = {22'd0, r_repeat_pause};
            default:                   prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Keyer state
    // ------------------------------------------------------------------
    mtb_pkg::t_state     r_state, n_state;
    logic [9:0]          r_pause_left, n_pause_left;
    logic [9:0]          r_symbol_left, n_symbol_left;
    logic [2:0]          r_symbols, n_symbols;
    logic [5:0]          r_chars_left, n_chars_left;
    mtb_pkg::t_text_addr r_text_pos, n_text_pos;
    logic [7:0]          r_code, n_code;
    logic                r_light_state, n_light_state;
    logic                r_out_valid, n_out_valid;
    logic                r_light_out, n_light_out;

    logic                w_in_accept;
    logic                w_out_free;
    logic                w_scan_more;
    logic                w_start_scan;
    logic [7:0]          w_dit;
    logic [9:0]          w_dit3;
    logic [7:0]          w_rd_data;
    mtb_pkg::t_store_wr  w_wr;
    mtb_pkg::t_text_addr w_pos_inc;

    assign o_in_stall  = (r_state != mtb_pkg::S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_light_on  = r_light_out;

    // A dit length of zero counts as one
    assign w_dit  = (r_dit_ticks == 8'd0) ? 8'd1 : r_dit_ticks;
    assign w_dit3 = {2'b00, w_dit} + {1'b0, w_dit, 1'b0};

    assign w_start_scan = (r_pause_left == 10'd0) && (r_symbol_left == 10'd0)
                       && (r_symbols == 3'd0) && (r_chars_left != 6'd0);

    // Advance the read position, wrap at the end of the store
    assign w_pos_inc = (r_text_pos == mtb_pkg::t_text_addr'(mtb_pkg::TEXT_DEPTH - 1))
                     ? '0 : r_text_pos + 1'b1;

    // Writes beyond the store depth are dropped
    assign w_wr.en   = w_in_accept && (i_action == mtb_pkg::ACT_WRITE)
                    && (int'(i_text_index) < mtb_pkg::TEXT_DEPTH);
    assign w_wr.addr = mtb_pkg::t_text_addr'(i_text_index);
    assign w_wr.data = i_text_char;

    // Read at the next position, so the data lines up with the scan cycle
    mtb_text_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (n_text_pos),
        .o_rd_data (w_rd_data)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtb_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    n_state = (i_action == mtb_pkg::ACT_WRITE)
                            ? mtb_pkg::S_DONE : mtb_pkg::S_TICK;
                end
            end
            mtb_pkg::S_TICK: begin
                n_state = w_start_scan ? mtb_pkg::S_SCAN : mtb_pkg::S_DONE;
            end
            mtb_pkg::S_SCAN: begin
                n_state = w_scan_more ? mtb_pkg::S_SCAN : mtb_pkg::S_DONE;
            end
            mtb_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = mtb_pkg::S_IDLE;
                end
            end
            default: n_state = mtb_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath: one keyer step per tick, one character per scan cycle
    // ------------------------------------------------------------------
    always_comb begin
        n_pause_left  = r_pause_left;
        n_symbol_left = r_symbol_left;
        n_symbols     = r_symbols;
        n_chars_left  = r_chars_left;
        n_text_pos    = r_text_pos;
        n_code        = r_code;
        n_light_state = r_light_state;
        n_out_valid   = r_out_valid;
        n_light_out   = r_light_out;
        w_scan_more   = 1'b0;

        // Drop the result once the receiver takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            mtb_pkg::S_TICK: begin
                if (r_pause_left != 10'd0) begin
                    n_pause_left = r_pause_left - 10'd1;
                end else if (r_symbol_left != 10'd0) begin
                    n_symbol_left = r_symbol_left - 10'd1;
                    // Symbol done: light off, inter-symbol or character gap
                    if (r_symbol_left == 10'd1) begin
                        n_light_state = 1'b0;
                        n_pause_left  = (r_symbols != 3'd0) ? {2'b00, w_dit} : w_dit3;
                    end
                end else if (r_symbols != 3'd0) begin
                    n_symbol_left = r_code[7] ? w_dit3 : {2'b00, w_dit};
                    n_light_state = 1'b1;
                    n_code        = {r_code[6:0], 1'b0};
                    n_symbols     = r_symbols - 3'd1;
                end else if (r_chars_left == 6'd0) begin
                    // End of text: pause, then restart from the top
                    n_pause_left = r_repeat_pause;
                    n_text_pos   = '0;
                    n_chars_left = r_text_length;
                end
            end
            mtb_pkg::S_SCAN: begin
                n_text_pos = w_pos_inc;
                if (w_rd_data == mtb_pkg::CHAR_SPACE) begin
                    // Space keeps the code register
                    n_pause_left = r_word_pause;
                end else begin
                    n_code    = mtb_pkg::code_of(w_rd_data);
                    n_symbols = mtb_pkg::length_of(n_code);
                end
                n_chars_left = r_chars_left - 6'd1;
                w_scan_more  = (n_code == 8'd0) && (n_chars_left != 6'd0);
            end
            mtb_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_light_out = r_light_state;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mtb_pkg::S_IDLE;
            r_pause_left  <= 10'd0;
            r_symbol_left <= 10'd0;
            r_symbols     <= 3'd0;
            r_chars_left  <= 6'd0;
            r_text_pos    <= '0;
            r_code        <= 8'd0;
            r_light_state <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pause_left  <= n_pause_left;
            r_symbol_left <= n_symbol_left;
            r_symbols     <= n_symbols;
            r_chars_left  <= n_chars_left;
            r_text_pos    <= n_text_pos;
            r_code        <= n_code;
            r_light_state <= n_light_state;
            r_out_valid   <= n_out_valid;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_light_out <= n_light_out;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The light is on exactly while a symbol is counting down
    a_light_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_light_state == (r_symbol_left != 10'd0))
        else $error("light state and symbol counter disagree");

    // A scan cycle always has a character left to read
    a_scan_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtb_pkg::S_SCAN) |-> (r_chars_left != 6'd0))
        else $error("scan with no characters left");

    // An accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state != mtb_pkg::S_IDLE))
        else $error("idle right after an accepted transaction");

endmodule

`default_nettype wire
